// ===== sv/swm_pkg.sv =====
// shared types and constants for the sliding window mean unit
package swm_pkg;

    localparam int SAMPLE_W = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // latch sample, read outgoing ring entry
        logic update;   // update sum, ring, index and count
        logic prep;     // load divider with |sum| and count
        logic step;     // one restoring division step
        logic out_load; // move signed quotient into the output register
    } t_swm_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_last; // current step is the last one
        logic out_free; // output register can take a new result
    } t_swm_sts;

endpackage

// ===== sv/swm_if.sv =====
// stream interfaces for the sample input and the mean output
interface swm_in_if import swm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] window_mean;

    modport source (output valid, output window_mean, input ready);
    modport sink   (input valid, input window_mean, output ready);
endinterface

// ===== sv/swm_ctrl.sv =====
// controller state machine for the sliding window mean unit
module swm_ctrl import swm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_swm_sts i_sts,
    output logic     o_in_ready,
    output t_swm_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/swm_dp.sv =====
// datapath: sample ring, running sum and restoring divider
module swm_dp import swm_pkg::*; #(
    parameter int WINDOW = 100
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_swm_cmd                   i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_ready,
    output t_swm_sts                   o_sts,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_window_mean
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W = $clog2(SUM_W);

    logic [SAMPLE_W-1:0]     r_ring [WINDOW];
    logic [IDX_W-1:0]        r_wr_idx;
    logic [CNT_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0]     r_rd_data;

    logic [SUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_divisor;
    logic                    r_neg;
    logic [STEP_W-1:0]       r_step;

    logic                    r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                    full;
    logic signed [SUM_W-1:0] outgoing;
    logic [CNT_W:0]          rem_sh;
    logic                    q_bit;
    logic [CNT_W:0]          rem_sub;
    logic [SAMPLE_W-1:0]     q_low;

    assign full     = (r_count == CNT_W'(WINDOW));
    assign outgoing = full ? SUM_W'(signed'(r_rd_data)) : '0;

    // restoring step: bring in next dividend bit, subtract if it fits
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_divisor});
    assign rem_sub = rem_sh - {1'b0, r_divisor};
    assign q_low   = r_quo[SAMPLE_W-1:0];

    assign o_sts.div_last = (r_step == STEP_W'(SUM_W - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_window_mean  = r_out_data;

    // ring memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_ring[r_wr_idx];
        end
        if (i_cmd.update) begin
            r_ring[r_wr_idx] <= r_sample;
        end
    end

    // window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_count  <= '0;
            r_sum    <= '0;
        end else if (i_cmd.update) begin
            r_sum <= r_sum + SUM_W'(r_sample) - outgoing;
            if (r_wr_idx == IDX_W'(WINDOW - 1)) begin
                r_wr_idx <= '0;
            end else begin
                r_wr_idx <= r_wr_idx + 1'b1;
            end
            if (!full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
    end

    // divider of |sum| by count, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_neg     <= r_sum[SUM_W-1];
            r_quo     <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem     <= '0;
            r_divisor <= r_count;
            r_step    <= '0;
        end else if (i_cmd.step) begin
            r_quo  <= {r_quo[SUM_W-2:0], q_bit};
            r_rem  <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_neg ? signed'(-q_low) : signed'(q_low);
        end
    end

endmodule

// ===== sv/sliding_window_mean_unit.sv =====
// top level of the sliding window mean unit
// usage
//   i_in carries one signed q15.16 sample per transaction (valid/ready)
//   o_out carries one signed q15.16 window mean per accepted sample
//   the mean covers the last WINDOW samples, or all samples seen so far
//   while the ring is still filling, truncated toward zero
// sequence
//   one sample in flight: accept, update the ring and sum, load the
//   divider, run the restoring divider (one quotient bit per cycle),
//   then load the result into the output register; i_in.ready is high
//   only while idle, so the next sample is taken only after the result
//   of the last one has been loaded into the output register
// reset
//   i_rst_n is synchronous and active low; it clears index, fill count,
//   running sum, controller state and output valid; ring entries are only
//   used once the ring is full, so the ring needs no clearing pass
// stall
//   a finished result waits in the output register; the next sample is
//   accepted meanwhile and its result is held in the divider until the
//   output register is free
module sliding_window_mean_unit import swm_pkg::*; #(
    parameter int WINDOW = 100
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swm_in_if.sink       i_in,
    swm_out_if.source    o_out
);

    t_swm_cmd cmd;
    t_swm_sts sts;
    logic     in_ready;

    assign i_in.ready = in_ready;

    // controller: sequences one sample at a time
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // datapath: ring memory, running sum, divider and output register
    swm_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (i_in.sample),
        .i_out_ready   (o_out.ready),
        .o_sts         (sts),
        .o_out_valid   (o_out.valid),
        .o_window_mean (o_out.window_mean)
    );

endmodule

// ===== sv/swm_chk.sv =====
// port level checks for the sliding window mean unit
module swm_chk import swm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_out_mean
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_mean)))
        else $error("stalled result changed");

    // one sample at a time: busy right after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after transaction");

    // no result can appear the cycle after a sample is taken
    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too early");

endmodule

bind sliding_window_mean_unit swm_chk u_swm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mean  (o_out.window_mean)
);

// ===== test/tb_top.sv =====
// testbench for the sliding window mean unit: predicted means checked against the output stream
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int WINDOW      = 100;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);
    localparam int ITEMS       = 850;
    localparam int MAX_GAP     = 11;
    localparam int HOLD_AT     = 300;    // result count at which the long hold-off starts
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 60;     // extra wait for stray results after the last owed mean
    localparam int LIMIT       = 400000;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [SAMPLE_W-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // predictor of the moving average plus the queue of means still owed by the block
    class mean_scoreboard;
        logic signed [SAMPLE_W-1:0] ring [WINDOW];
        logic [CNT_W-1:0]           slot;
        logic [CNT_W-1:0]           held;
        logic signed [SUM_W-1:0]    total;
        logic signed [SAMPLE_W-1:0] pending_means[$];
        int                         mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            slot       = '0;
            held       = '0;
            total      = '0;
            mismatches = 0;
        endfunction

        // one accepted sample: update ring and sum, owe its mean
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            logic signed [SAMPLE_W-1:0] outgoing;
            logic signed [SUM_W-1:0]    quotient;
            outgoing = '0;
            // nothing leaves the sum while the ring is still filling
            if (held == CNT_W'(WINDOW)) begin
                outgoing = ring[slot];
            end else begin
                held = held + 1'b1;
            end
            ring[slot] = s;
            total      = total + s - outgoing;
            slot       = (slot == CNT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
            // signed division truncates toward zero
            quotient = total / $signed({{(SUM_W-CNT_W){1'b0}}, held});
            pending_means.insert(pending_means.size(), quotient[SAMPLE_W-1:0]);
        endfunction

        // one result transaction from the block
        function void check_mean(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] predicted;
            if (pending_means.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected window_mean %0d, nothing pending", $time, actual);
            end else begin
                predicted = pending_means.pop_front();
                if (actual !== predicted) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: window_mean mismatch, expected %0d (0x%08h) got %0d (0x%08h)",
                                 $time, predicted, predicted, actual, actual);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    swm_in_if  in_if ();
    swm_out_if out_if ();

    mean_scoreboard sb = new();

    bit tx_idle;     // sender gaps enabled for the current segment
    bit rx_idle;     // receiver stalls enabled for the current stretch
    int sent;

    sliding_window_mean_unit #(
        .WINDOW (WINDOW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: generous bound on the whole run
    initial begin
        int cycles;
        for (cycles = 0; cycles < LIMIT; cycles++) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // offer one sample, keep valid high when the next one follows without a gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        @(posedge i_clk);
        // handshake seen with the values that were present at the edge
        while (!in_if.ready) @(posedge i_clk);
        sb.note_sample(s);
        sent++;
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int stall;
        int results;
        results = 0;
        rx_idle = 1'b1;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (results == HOLD_AT) begin
                // sender keeps offering, so the block fills and drops its ready
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            sb.check_mean(out_if.window_mean);
            results++;
            // switch between stalling and streaming now and then
            if (results % 40 == 0)
                rx_idle = ($urandom_range(0, 2) != 0);
        end
    end

    // stimulus and end of run
    initial begin
        logic signed [SAMPLE_W-1:0] directed [];
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] fill_value;
        int kind;
        int seg_len;
        int k;

        sent = 0;
        tx_idle = 1'b1;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        i_rst_n      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, sign changes, truncation toward zero while filling
        directed = '{
            32'sh0000_0000, MAX_SAMPLE, MIN_SAMPLE, MIN_SAMPLE, MAX_SAMPLE,
            -32'sd1, 32'sd1, -32'sd1, -32'sd2, 32'sd3,
            32'sh0001_0000, 32'shFFFF_0000, 32'sh5555_5555, 32'shAAAA_AAAA,
            32'sh0000_0001, 32'shFFFF_FFFF, -32'sd7, 32'sd5, MIN_SAMPLE, MAX_SAMPLE,
            32'sh8000_0001, 32'sh7FFF_FFFE
        };
        foreach (directed[i]) send_sample(directed[i]);

        // full window of the largest sample, back to back: largest positive sum
        tx_idle = 1'b0;
        for (k = 0; k < WINDOW + 10; k++) send_sample(MAX_SAMPLE);
        // then of the smallest, with gaps: the first WINDOW outgoing entries are the opposite extreme
        tx_idle = 1'b1;
        for (k = 0; k < WINDOW + 10; k++) send_sample(MIN_SAMPLE);

        // random segments of differing character, many wraps of the ring
        while (sent < ITEMS) begin
            kind       = $urandom_range(0, 4);
            seg_len    = $urandom_range(8, 60);
            tx_idle    = ($urandom_range(0, 3) != 0);
            fill_value = $urandom;
            for (k = 0; k < seg_len && sent < ITEMS; k++) begin
                case (kind)
                    0: s = $urandom;
                    // small magnitudes, negative means exercise truncation
                    1: s = int'($urandom_range(0, 8)) - 4;
                    2: s = fill_value;
                    // random magnitude with the sign kept
                    3: s = int'($urandom) >>> $urandom_range(0, 31);
                    default: s = $urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE;
                endcase
                send_sample(s);
            end
        end
        in_if.valid <= 1'b0;

        // wait for every owed mean, then a little longer for strays
        while (sb.pending_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_means.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
